[design/swl_pkg.sv]
// ----------------------------------------------------------------------------
// swl_pkg
// Shared types and constants for the stop-and-wait link endpoint.
// ----------------------------------------------------------------------------
`default_nettype none

package swl_pkg;

	typedef logic [1:0] swl_opcode_t;
	typedef logic [7:0] swl_seq_t;

	// Item kinds; the fourth code is unused and does nothing
	localparam swl_opcode_t OP_TICK   = 2'd0;
	localparam swl_opcode_t OP_OFFER  = 2'd1;
	localparam swl_opcode_t OP_RX_HDR = 2'd2;

	// Register map: byte address bit 2 selects the register
	localparam int unsigned APB_ADDR_W = 3;
	localparam logic CFG_ACK_WAIT = 1'b0;
	localparam logic CFG_SEND_ACK = 1'b1;

	localparam logic [15:0] ACK_WAIT_RESET = 16'd2000;
	localparam swl_seq_t    SEQ_WRAP       = 8'd255;

	typedef struct packed {
		swl_opcode_t opcode;
		swl_seq_t    rx_seq;
		swl_seq_t    rx_ack;
		logic        rx_has_payload;
		logic        downstream_ready;
	} swl_item_t;

	typedef struct packed {
		logic     frame_send;
		swl_seq_t frame_seq;
		swl_seq_t frame_ack;
		logic     frame_has_data;
		logic     offer_accepted;
		logic     deliver_payload;
		logic     drop_payload;
		logic     ack_timeout;
	} swl_result_t;

	// Sequence numbers run 1..255; zero only after reset
	function automatic swl_seq_t next_seq(input swl_seq_t n);
		next_seq = (n == SEQ_WRAP) ? 8'd1 : n + 8'd1;
	endfunction

endpackage

`default_nettype wire

[design/swl_if.sv]
// ----------------------------------------------------------------------------
// swl_item_if / swl_result_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface swl_item_if import swl_pkg::*; ();
	logic      valid;
	logic      ready;
	swl_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface swl_result_if import swl_pkg::*; ();
	logic        valid;
	logic        ready;
	swl_result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/swl_cfg_regs.sv]
// ----------------------------------------------------------------------------
// swl_cfg_regs
// APB register file holding the two timer reload values.
// ----------------------------------------------------------------------------
`default_nettype none

module swl_cfg_regs import swl_pkg::*; #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	output logic      [TIMER_BITS-1:0] ack_wait_timeout_q,
	output logic      [TIMER_BITS-1:0] send_ack_timeout_q
);

	logic                  wr_en;
	logic [TIMER_BITS-1:0] wr_val;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	// Write data bits 15:0, sized to the timer width
	assign wr_val = TIMER_BITS'(pwdata[15:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_wait_timeout_q <= TIMER_BITS'(ACK_WAIT_RESET);
			send_ack_timeout_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[2])
				CFG_ACK_WAIT: ack_wait_timeout_q <= wr_val;
				CFG_SEND_ACK: send_ack_timeout_q <= wr_val;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			CFG_ACK_WAIT: prdata = 32'(ack_wait_timeout_q);
			CFG_SEND_ACK: prdata = 32'(send_ack_timeout_q);
			default:      prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[design/swl_core.sv]
// ----------------------------------------------------------------------------
// swl_core
// Protocol state, its combinational update and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module swl_core import swl_pkg::*; #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  advance,
	input  wire swl_item_t             item_s1,
	input  wire logic [TIMER_BITS-1:0] ack_wait_timeout,
	input  wire logic [TIMER_BITS-1:0] send_ack_timeout,
	output swl_result_t                result_s2
);

	swl_seq_t              send_seq_q, send_seq_d;
	swl_seq_t              expect_seq_q, expect_seq_d;
	logic                  awaiting_ack_q, awaiting_ack_d;
	logic                  timeout_reported_q, timeout_reported_d;
	logic                  ack_due_q, ack_due_d;
	logic [TIMER_BITS-1:0] ack_wait_left_q, ack_wait_left_d;
	logic [TIMER_BITS-1:0] ack_delay_left_q, ack_delay_left_d;
	swl_seq_t              expect_resync;
	swl_result_t           res;

	always_comb begin
		send_seq_d         = send_seq_q;
		expect_seq_d       = expect_seq_q;
		awaiting_ack_d     = awaiting_ack_q;
		timeout_reported_d = timeout_reported_q;
		ack_due_d          = ack_due_q;
		ack_wait_left_d    = ack_wait_left_q;
		ack_delay_left_d   = ack_delay_left_q;
		res                = '0;
		expect_resync      = expect_seq_q;

		case (item_s1.opcode)
			OP_TICK: begin
				if (awaiting_ack_q && !timeout_reported_q) begin
					if (ack_wait_left_q == '0) begin
						res.ack_timeout    = 1'b1;
						timeout_reported_d = 1'b1;
					end else begin
						ack_wait_left_d = ack_wait_left_q - TIMER_BITS'(1);
					end
				end
				if (ack_due_q) begin
					if (ack_delay_left_q == '0) begin
						res.frame_send = 1'b1;
						res.frame_seq  = send_seq_q;
						res.frame_ack  = expect_seq_q;
						ack_due_d      = 1'b0;
					end else begin
						ack_delay_left_d = ack_delay_left_q - TIMER_BITS'(1);
					end
				end
			end
			OP_OFFER: begin
				if (!awaiting_ack_q && item_s1.downstream_ready) begin
					res.frame_send     = 1'b1;
					res.frame_seq      = send_seq_q;
					res.frame_ack      = expect_seq_q;
					res.frame_has_data = 1'b1;
					res.offer_accepted = 1'b1;
					ack_due_d          = 1'b0;
					ack_delay_left_d   = '0;
					awaiting_ack_d     = 1'b1;
					ack_wait_left_d    = ack_wait_timeout;
					timeout_reported_d = 1'b0;
				end
			end
			OP_RX_HDR: begin
				// A zero field means the peer restarted: take its sequence
				if (item_s1.rx_seq == '0 || item_s1.rx_ack == '0) begin
					expect_resync = item_s1.rx_seq;
				end
				if (awaiting_ack_q && item_s1.rx_ack == next_seq(send_seq_q)) begin
					send_seq_d         = item_s1.rx_ack;
					awaiting_ack_d     = 1'b0;
					ack_wait_left_d    = '0;
					timeout_reported_d = 1'b0;
				end
				if (expect_resync == item_s1.rx_seq) begin
					expect_seq_d        = next_seq(expect_resync);
					ack_due_d           = 1'b1;
					ack_delay_left_d    = send_ack_timeout;
					res.deliver_payload = item_s1.rx_has_payload;
				end else begin
					expect_seq_d     = expect_resync;
					res.drop_payload = item_s1.rx_has_payload;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_seq_q         <= '0;
			expect_seq_q       <= '0;
			awaiting_ack_q     <= 1'b0;
			timeout_reported_q <= 1'b0;
			ack_due_q          <= 1'b0;
			ack_wait_left_q    <= '0;
			ack_delay_left_q   <= '0;
		end else if (advance) begin
			send_seq_q         <= send_seq_d;
			expect_seq_q       <= expect_seq_d;
			awaiting_ack_q     <= awaiting_ack_d;
			timeout_reported_q <= timeout_reported_d;
			ack_due_q          <= ack_due_d;
			ack_wait_left_q    <= ack_wait_left_d;
			ack_delay_left_q   <= ack_delay_left_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= res;
		end
	end

endmodule

`default_nettype wire

[design/stop_and_wait_link_endpoint.sv]
// ----------------------------------------------------------------------------
// stop_and_wait_link_endpoint
// Stop-and-wait link endpoint: sequencing, acknowledgement and timers.
// ----------------------------------------------------------------------------
// Usage:
//   item   : input channel; each transaction is a tick, a transmit offer or
//            a received frame header (opcode selects which).
//   result : output channel; exactly one result transaction per item, in
//            order, telling what frame to emit and what to do with payloads.
//   APB    : two timer registers, ack_wait_timeout at 0x0 and
//            send_ack_timeout at 0x4; write them only while the block idles.
// An item is held in the input register, then the state update loads the
// result register, from which result valid rises. Throughput is one item
// per cycle while the result receiver does not stall; the state update is
// a single registered pass, so the next item sees the previous item's
// effects with no bubble.
// Reset clears both sequence numbers and all timers to zero, reloads the
// registers (ack_wait_timeout 2000, send_ack_timeout 0) and empties both
// stages. When the result receiver stalls, the result register holds, the
// input register fills, and item.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module stop_and_wait_link_endpoint import swl_pkg::*; #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	swl_item_if.sink                   item,
	swl_result_if.source               result,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready
);

	logic                  valid_s1;
	logic                  valid_s2;
	swl_item_t             item_s1;
	swl_result_t           result_s2;
	logic                  advance;
	logic                  item_fire;
	logic [TIMER_BITS-1:0] ack_wait_timeout;
	logic [TIMER_BITS-1:0] send_ack_timeout;

	// Advance the held item into the result stage when that stage is empty
	// or its result is taken this cycle.
	assign advance   = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign item_fire  = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the payload only on an accepted transaction
	always_ff @(posedge clk) begin
		if (item_fire) begin
			item_s1 <= item.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	swl_cfg_regs #(
		.TIMER_BITS(TIMER_BITS)
	) u_cfg (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.ack_wait_timeout_q(ack_wait_timeout),
		.send_ack_timeout_q(send_ack_timeout)
	);

	// State and result register; state moves only when an item advances
	swl_core #(
		.TIMER_BITS(TIMER_BITS)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (advance),
		.item_s1         (item_s1),
		.ack_wait_timeout(ack_wait_timeout),
		.send_ack_timeout(send_ack_timeout),
		.result_s2       (result_s2)
	);

	assign result.valid = valid_s2;
	assign result.data  = result_s2;

endmodule

`default_nettype wire

[design/swl_checker.sv]
// ----------------------------------------------------------------------------
// swl_checker
// Port-level checks of the endpoint's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module swl_checker import swl_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire swl_result_t res_data
);

	// A pending result stays offered until taken
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped before transaction completed");

	// No frame means empty header fields
	a_idle_header: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.frame_send |->
		res_data.frame_seq == '0 && res_data.frame_ack == '0)
		else $error("header fields set without a frame");

	// A payload is either fresh or duplicate, never both
	a_deliver_drop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_data.deliver_payload && res_data.drop_payload))
		else $error("payload both delivered and dropped");

	// An accepted offer always goes out as a data frame
	a_offer_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.offer_accepted |->
		res_data.frame_send && res_data.frame_has_data)
		else $error("accepted offer without a data frame");

	// Data frames come only from accepted offers, never with a delivery or a timeout flag
	a_data_source: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.frame_has_data |->
		res_data.offer_accepted && !res_data.deliver_payload && !res_data.ack_timeout)
		else $error("data frame without an accepted offer");

endmodule

bind stop_and_wait_link_endpoint swl_checker u_swl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.res_data (result.data)
);

`default_nettype wire
